@@ rtl/ntp_offset_delay_calc_macros.svh @@
// Assertion macros for the NTP offset and delay pipeline.
// Used by modules that check their own pipeline control; relies on clk and arst_n in scope.
`ifndef NTP_OFFSET_DELAY_CALC_MACROS_SVH
`define NTP_OFFSET_DELAY_CALC_MACROS_SVH

// Check a property on every clock edge outside reset.
`define NTP_ODC_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that one condition implies another on the next clock edge.
`define NTP_ODC_CHECK_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/ntp_odc_pkg.sv @@
// Shared types and constants for the NTP offset and delay pipeline.
// No dependencies.
`default_nettype none

package ntp_odc_pkg;

	localparam logic [29:0]        NS_PER_SEC    = 30'd1000000000;
	localparam logic [29:0]        NS_LAST       = 30'd999999999;
	localparam logic signed [36:0] EPOCH_GAP_SEC = 37'sd2208988800;

	// Seconds and raw nanosecond parts of offset numerator and delay
	typedef struct packed {
		logic signed [36:0] so_sec;
		logic signed [36:0] sd_sec;
		logic signed [32:0] fo_ns;
		logic signed [32:0] fd_ns;
	} mid_t;

endpackage

`default_nettype wire

@@ rtl/ntp_offset_delay_calc.sv @@
// NTP clock offset and round-trip delay, four-stage pipeline.
// Data passes through stages 1 to 4 in order; an output stall holds the result in stage 4.
// Throughput: one item per cycle unless out_stall; stalls drop nothing, bubbles fill.
// Reset (arst_n low, asynchronous) clears all stage valid bits; payload is not reset.
// Stage 1 holds the three 32x30 fraction products, which set the critical path.
`default_nettype none

module ntp_offset_delay_calc import ntp_odc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        t1_sec,
	input  logic [31:0]        t1_frac,
	input  logic [31:0]        t2_sec,
	input  logic [31:0]        t2_frac,
	input  logic [31:0]        t3_sec,
	input  logic [31:0]        t3_frac,
	input  logic [30:0]        t4_sec,
	input  logic [29:0]        t4_nsec,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [32:0] ofs_sec,
	output logic [29:0]        ofs_ns,
	output logic signed [33:0] rtd_sec,
	output logic [29:0]        rtd_ns
);

	logic mid_valid, mid_stall;
	mid_t mid;

	ntp_odc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.t1_sec    (t1_sec),
		.t1_frac   (t1_frac),
		.t2_sec    (t2_sec),
		.t2_frac   (t2_frac),
		.t3_sec    (t3_sec),
		.t3_frac   (t3_frac),
		.t4_sec    (t4_sec),
		.t4_nsec   (t4_nsec),
		.mid_valid (mid_valid),
		.mid_stall (mid_stall),
		.mid       (mid)
	);

	ntp_odc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_stall  (mid_stall),
		.mid       (mid),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ofs_sec   (ofs_sec),
		.ofs_ns    (ofs_ns),
		.rtd_sec   (rtd_sec),
		.rtd_ns    (rtd_ns)
	);

endmodule

`default_nettype wire

@@ rtl/ntp_odc_front.sv @@
// Front half of the pipeline: fraction to nanosecond products, seconds sums, ns sums.
// Depends on ntp_odc_pkg.
`default_nettype none

module ntp_odc_front import ntp_odc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] t1_sec,
	input  logic [31:0] t1_frac,
	input  logic [31:0] t2_sec,
	input  logic [31:0] t2_frac,
	input  logic [31:0] t3_sec,
	input  logic [31:0] t3_frac,
	input  logic [30:0] t4_sec,
	input  logic [29:0] t4_nsec,
	output logic        mid_valid,
	input  logic        mid_stall,
	output mid_t        mid
);

	logic v_s1, v_s2, en_s1, en_s2;
	logic [61:0] p1, p2, p3;
	logic [29:0] f1_s1, f2_s1, f3_s1, t4n_s1;
	logic signed [36:0] so_s1, sd_s1;
	logic signed [36:0] e1, e2, e3, e4;
	mid_t mid_s2;

	assign en_s2    = !v_s2 || !mid_stall;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	assign p1 = 62'(t1_frac) * 62'(NS_PER_SEC);
	assign p2 = 62'(t2_frac) * 62'(NS_PER_SEC);
	assign p3 = 62'(t3_frac) * 62'(NS_PER_SEC);

	assign e1 = $signed({5'b0, t1_sec});
	assign e2 = $signed({5'b0, t2_sec});
	assign e3 = $signed({5'b0, t3_sec});
	assign e4 = $signed({6'b0, t4_sec});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			f1_s1  <= p1[61:32];
			f2_s1  <= p2[61:32];
			f3_s1  <= p3[61:32];
			t4n_s1 <= t4_nsec;
			so_s1  <= e2 - e1 + e3 - EPOCH_GAP_SEC - e4;
			sd_s1  <= e4 - e1 + EPOCH_GAP_SEC - e3 + e2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			mid_s2.so_sec <= so_s1;
			mid_s2.sd_sec <= sd_s1;
			mid_s2.fo_ns  <= $signed({3'b0, f2_s1}) - $signed({3'b0, f1_s1})
				+ $signed({3'b0, f3_s1}) - $signed({3'b0, t4n_s1});
			mid_s2.fd_ns  <= $signed({3'b0, t4n_s1}) - $signed({3'b0, f1_s1})
				- $signed({3'b0, f3_s1}) + $signed({3'b0, f2_s1});
		end
	end

	assign mid_valid = v_s2;
	assign mid       = mid_s2;

endmodule

`default_nettype wire

@@ rtl/ntp_odc_back.sv @@
// Back half of the pipeline: fold nanoseconds into range, halve the offset toward zero.
// Depends on ntp_odc_pkg and the assertion macro header.
`default_nettype none

`include "ntp_offset_delay_calc_macros.svh"

module ntp_odc_back import ntp_odc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mid_t               mid,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [32:0] ofs_sec,
	output logic [29:0]        ofs_ns,
	output logic signed [33:0] rtd_sec,
	output logic [29:0]        rtd_ns
);

	typedef struct packed {
		logic signed [2:0] carry;
		logic [29:0]       ns;
	} fold_t;

	localparam logic signed [32:0] NS1 = 33'sd1000000000;
	localparam logic signed [32:0] NS2 = 33'sd2000000000;
	localparam logic signed [32:0] NS3 = 33'sd3000000000;

	function automatic fold_t fold_ns(input logic signed [32:0] f);
		fold_t r;
		if (f >= NS2) begin
			r.carry = 3'sd2;
			r.ns    = 30'(f - NS2);
		end else if (f >= NS1) begin
			r.carry = 3'sd1;
			r.ns    = 30'(f - NS1);
		end else if (f >= 33'sd0) begin
			r.carry = 3'sd0;
			r.ns    = 30'(f);
		end else if (f >= -NS1) begin
			r.carry = -3'sd1;
			r.ns    = 30'(f + NS1);
		end else if (f >= -NS2) begin
			r.carry = -3'sd2;
			r.ns    = 30'(f + NS2);
		end else begin
			r.carry = -3'sd3;
			r.ns    = 30'(f + NS3);
		end
		return r;
	endfunction

	logic v_s3, v_s4, en_s3, en_s4;
	fold_t fo, fd;
	logic signed [36:0] so_s3;
	logic [29:0] ro_s3, rd_s3;
	logic signed [33:0] sd_s3;
	logic signed [36:0] half_sec;
	logic [30:0] ns_sum;
	logic [29:0] half_ns;
	logic fix;
	logic signed [36:0] off_sec_c;
	logic [29:0] off_ns_c;
	logic signed [32:0] ofs_sec_s4;
	logic [29:0] ofs_ns_s4, rtd_ns_s4;
	logic signed [33:0] rtd_sec_s4;

	assign en_s4    = !v_s4 || !out_stall;
	assign en_s3    = !v_s3 || en_s4;
	assign in_stall = !en_s3;

	assign fo = fold_ns(mid.fo_ns);
	assign fd = fold_ns(mid.fd_ns);

	// Floor halving, then step toward zero for a negative odd numerator
	always_comb begin
		half_sec = so_s3 >>> 1;
		ns_sum   = {1'b0, ro_s3} + (so_s3[0] ? {1'b0, NS_PER_SEC} : 31'd0);
		half_ns  = ns_sum[30:1];
		fix      = so_s3[36] & ro_s3[0];
		off_sec_c = half_sec;
		off_ns_c  = half_ns;
		if (fix) begin
			if (half_ns == NS_LAST) begin
				off_sec_c = half_sec + 37'sd1;
				off_ns_c  = 30'd0;
			end else begin
				off_ns_c = half_ns + 30'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			so_s3 <= mid.so_sec + {{34{fo.carry[2]}}, fo.carry};
			ro_s3 <= fo.ns;
			sd_s3 <= 34'(mid.sd_sec + {{34{fd.carry[2]}}, fd.carry});
			rd_s3 <= fd.ns;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ofs_sec_s4 <= off_sec_c[32:0];
			ofs_ns_s4  <= off_ns_c;
			rtd_sec_s4 <= sd_s3;
			rtd_ns_s4  <= rd_s3;
		end
	end

	assign out_valid = v_s4;
	assign ofs_sec   = ofs_sec_s4;
	assign ofs_ns    = ofs_ns_s4;
	assign rtd_sec   = rtd_sec_s4;
	assign rtd_ns    = rtd_ns_s4;

	`NTP_ODC_CHECK(a_off_ns_range, out_valid |-> (ofs_ns <= NS_LAST), "offset ns out of range")
	`NTP_ODC_CHECK(a_dly_ns_range, out_valid |-> (rtd_ns <= NS_LAST), "delay ns out of range")
	`NTP_ODC_CHECK(a_stall_full, in_stall |-> (v_s3 && v_s4 && out_stall), "stall with room free")
	`NTP_ODC_CHECK_NEXT(a_drain, v_s4 && !out_stall && !v_s3, !out_valid, "result repeated")

endmodule

`default_nettype wire

@@ tb/ntp_offset_delay_calc_checker.sv @@
// Checker for the NTP offset and delay block: watches both channels, predicts each
// result from the input transfer and compares it field by field.
// Standalone; needs nothing but the ports it is bound to.
module ntp_offset_delay_calc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [31:0]        t1_sec,
	input  logic [31:0]        t1_frac,
	input  logic [31:0]        t2_sec,
	input  logic [31:0]        t2_frac,
	input  logic [31:0]        t3_sec,
	input  logic [31:0]        t3_frac,
	input  logic [30:0]        t4_sec,
	input  logic [29:0]        t4_nsec,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [32:0] ofs_sec,
	input  logic [29:0]        ofs_ns,
	input  logic signed [33:0] rtd_sec,
	input  logic [29:0]        rtd_ns,
	output int                 fail_count,
	output int                 outstanding
);

	localparam longint EPOCH_GAP_S = 64'sd2208988800;
	localparam longint NS_IN_SEC   = 64'sd1000000000;

	typedef struct packed {
		logic signed [32:0] off_sec;
		logic [29:0]        off_nsec;
		logic signed [33:0] dly_sec;
		logic [29:0]        dly_nsec;
	} offset_delay_t;

	offset_delay_t expected_q[$];

	function automatic longint ntp_ns(logic [31:0] sec, logic [31:0] frac);
		logic [63:0] scaled;
		longint      whole;
		scaled = ({32'd0, frac} * 64'd1000000000) >> 32;
		whole  = longint'({32'd0, sec}) - EPOCH_GAP_S;
		return whole * NS_IN_SEC + longint'(scaled);
	endfunction

	function automatic void floor_split(longint ns, output longint sec, output longint nsec);
		sec  = ns / NS_IN_SEC;
		nsec = ns % NS_IN_SEC;
		if (nsec < 0) begin
			nsec = nsec + NS_IN_SEC;
			sec  = sec - 1;
		end
	endfunction

	function automatic offset_delay_t calc_offset_delay(
		logic [31:0] a_s, logic [31:0] a_f, logic [31:0] b_s, logic [31:0] b_f,
		logic [31:0] c_s, logic [31:0] c_f, logic [30:0] d_s, logic [29:0] d_n);
		longint        a, b, c, d, off_ns, dly_ns, q, r;
		offset_delay_t res;
		a = ntp_ns(a_s, a_f);
		b = ntp_ns(b_s, b_f);
		c = ntp_ns(c_s, c_f);
		d = longint'({33'd0, d_s}) * NS_IN_SEC + longint'({34'd0, d_n});
		off_ns = ((b - a) + (c - d)) / 2;
		dly_ns = (d - a) - (c - b);
		floor_split(off_ns, q, r);
		res.off_sec  = q[32:0];
		res.off_nsec = r[29:0];
		floor_split(dly_ns, q, r);
		res.dly_sec  = q[33:0];
		res.dly_nsec = r[29:0];
		return res;
	endfunction

	task automatic report(string text);
		if (fail_count < 20)
			$display("error at %0t: %s", $time, text);
		fail_count++;
	endtask

	always @(posedge clk) begin : monitor
		offset_delay_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_q.push_back(calc_offset_delay(t1_sec, t1_frac, t2_sec, t2_frac,
					t3_sec, t3_frac, t4_sec, t4_nsec));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report($sformatf("unexpected transfer: offset %0d.%0d delay %0d.%0d",
						ofs_sec, ofs_ns, rtd_sec, rtd_ns));
				end else begin
					want = expected_q.pop_front();
					if (ofs_sec !== want.off_sec)
						report($sformatf("ofs_sec got %0d want %0d", ofs_sec, want.off_sec));
					if (ofs_ns !== want.off_nsec)
						report($sformatf("ofs_ns got %0d want %0d", ofs_ns,
							want.off_nsec));
					if (rtd_sec !== want.dly_sec)
						report($sformatf("rtd_sec got %0d want %0d", rtd_sec, want.dly_sec));
					if (rtd_ns !== want.dly_nsec)
						report($sformatf("rtd_ns got %0d want %0d", rtd_ns,
							want.dly_nsec));
				end
			end
		end
		outstanding = expected_q.size();
	end

endmodule

@@ tb/ntp_offset_delay_calc_tb.sv @@
// Top of the NTP offset and delay testbench: clock, reset, directed and random
// timestamp sets, output stall patterns and the verdict.
// Depends on ntp_offset_delay_calc and ntp_offset_delay_calc_checker.
module ntp_offset_delay_calc_tb;

	localparam logic [31:0] EPOCH_GAP = 32'd2208988800;
	localparam int          RANDOM_SETS = 850;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [31:0]        t1_sec, t1_frac, t2_sec, t2_frac, t3_sec, t3_frac;
	logic [30:0]        t4_sec;
	logic [29:0]        t4_nsec;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [32:0] ofs_sec;
	logic [29:0]        ofs_ns;
	logic signed [33:0] rtd_sec;
	logic [29:0]        rtd_ns;
	int                 fail_count;
	int                 outstanding;

	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;
	logic [2:0]  stall_phase = 3'd0;

	ntp_offset_delay_calc dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.t1_sec(t1_sec), .t1_frac(t1_frac), .t2_sec(t2_sec), .t2_frac(t2_frac),
		.t3_sec(t3_sec), .t3_frac(t3_frac), .t4_sec(t4_sec), .t4_nsec(t4_nsec),
		.out_valid(out_valid), .out_stall(out_stall),
		.ofs_sec(ofs_sec), .ofs_ns(ofs_ns),
		.rtd_sec(rtd_sec), .rtd_ns(rtd_ns)
	);

	ntp_offset_delay_calc_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.t1_sec(t1_sec), .t1_frac(t1_frac), .t2_sec(t2_sec), .t2_frac(t2_frac),
		.t3_sec(t3_sec), .t3_frac(t3_frac), .t4_sec(t4_sec), .t4_nsec(t4_nsec),
		.out_valid(out_valid), .out_stall(out_stall),
		.ofs_sec(ofs_sec), .ofs_ns(ofs_ns),
		.rtd_sec(rtd_sec), .rtd_ns(rtd_ns),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(16, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_phase <= stall_phase + 3'd1;
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 99) < 80);
			STALL_PERIODIC: out_stall <= stall_phase[2];
		endcase
	end

	task automatic send_set(logic [31:0] a_s, logic [31:0] a_f, logic [31:0] b_s,
		logic [31:0] b_f, logic [31:0] c_s, logic [31:0] c_f, logic [30:0] d_s,
		logic [29:0] d_n);
		bit taken;
		in_valid <= 1'b1;
		t1_sec   <= a_s;
		t1_frac  <= a_f;
		t2_sec   <= b_s;
		t2_frac  <= b_f;
		t3_sec   <= c_s;
		t3_frac  <= c_f;
		t4_sec   <= d_s;
		t4_nsec  <= d_n;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic hold_off(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Plausible client/server exchange: close timestamps, random fractions.
	task automatic send_exchange();
		logic [31:0] base, b_s, c_s;
		logic [30:0] d_s;
		if ($urandom_range(0, 7) == 0) begin
			base = $urandom_range(EPOCH_GAP - 1, 8);
			d_s  = 31'($urandom_range(0, 100));
		end else begin
			base = $urandom_range(32'hFFFFFFF0, EPOCH_GAP + 8);
			d_s  = 31'(base - EPOCH_GAP + $urandom_range(0, 2));
		end
		b_s = base + $urandom_range(0, 4) - 2;
		c_s = b_s + $urandom_range(0, 1);
		send_set(base, $urandom(), b_s, $urandom(), c_s, $urandom(), d_s,
			30'($urandom_range(0, 999999999)));
	endtask

	initial begin
		int sent;
		int burst;
		int next_drain;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		t1_sec   <= 32'd0;
		t1_frac  <= 32'd0;
		t2_sec   <= 32'd0;
		t2_frac  <= 32'd0;
		t3_sec   <= 32'd0;
		t3_frac  <= 32'd0;
		t4_sec   <= 31'd0;
		t4_nsec  <= 30'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_set(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 31'd0, 30'd0);
		send_set('1, '1, '1, '1, '1, '1, '1, '1);
		send_set(EPOCH_GAP, 32'd0, EPOCH_GAP, 32'd0, EPOCH_GAP, 32'd0, 31'd0, 30'd0);
		send_set(EPOCH_GAP, '1, EPOCH_GAP, '1, EPOCH_GAP, '1, 31'd0, 30'd999999999);
		send_set(EPOCH_GAP, 32'h80000000, EPOCH_GAP + 1, 32'h80000000, EPOCH_GAP + 1,
			32'hC0000000, 31'd1, 30'd500000000);
		// before 1970
		send_set(32'd0, 32'd1, 32'd1, 32'd0, 32'd2, '1, 31'd0, 30'd0);
		// nanoseconds past the end of the second
		send_set(EPOCH_GAP + 100, 32'd0, EPOCH_GAP + 100, 32'd0, EPOCH_GAP + 100, 32'd0,
			31'd100, '1);
		send_set('1, '1, '1, '1, '1, '1, 31'd2085978495, 30'd999999999);
		// floor seconds wrap
		send_set('1, '1, 32'd0, 32'd0, 32'd0, 32'd0, '1, '1);
		send_set(32'd0, 32'd0, '1, '1, 32'd0, 32'd0, '1, '1);
		// truncation toward zero of negative halves, and of a positive odd numerator
		send_set(EPOCH_GAP, 32'd0, EPOCH_GAP, 32'd0, EPOCH_GAP, 32'd0, 31'd0, 30'd1);
		send_set(EPOCH_GAP, 32'd0, EPOCH_GAP, 32'd0, EPOCH_GAP, 32'd0, 31'd0, 30'd3);
		send_set(EPOCH_GAP, 32'd0, EPOCH_GAP, 32'd0, EPOCH_GAP, 32'd5, 31'd0, 30'd0);
		// negative delay
		send_set(EPOCH_GAP + 10, 32'd0, EPOCH_GAP, 32'd0, EPOCH_GAP + 20, 32'd0, 31'd0, 30'd0);
		send_set(EPOCH_GAP + 5, 32'h1234, EPOCH_GAP + 3, 32'hFFFF0000, EPOCH_GAP + 3,
			32'hFFFFFFFF, 31'd4, 30'd999999999);
		repeat (4) send_exchange();
		drain_results();

		sent       = 0;
		next_drain = 250;
		while (sent < RANDOM_SETS) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				if ($urandom_range(0, 4) == 0)
					send_set($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
						$urandom(), 31'($urandom()), 30'($urandom()));
				else
					send_exchange();
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				hold_off($urandom_range(1, 8));
			if (sent >= next_drain) begin
				drain_results();
				next_drain += 250;
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
